// ===== sv/olst_pkg.sv =====
package olst_pkg;

  // Request operation codes.
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DEL_VAL = 3'd2;
  localparam logic [2:0] OP_DEL_POS = 3'd3;
  localparam logic [2:0] OP_FIND = 3'd4;
  localparam logic [2:0] OP_READ = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // One result item as it travels from the sequencer to the output register.
  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         found_index;
    logic [6:0]         length;
    logic signed [31:0] read_value;
  } result_t;

endpackage

// ===== sv/olst_if.sv =====
// Request channel: one operation per transfer.
interface olst_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [6:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink (input valid, input opcode, input position, input value, output ready);
endinterface

// Response channel: one result per transfer.
interface olst_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [5:0]         found_index;
  logic [6:0]         length;
  logic signed [31:0] read_value;

  modport source (output valid, output status, output found_index, output length,
                  output read_value, input ready);
  modport sink (input valid, input status, input found_index, input length,
                input read_value, output ready);
endinterface

// ===== sv/olst_mem.sv =====
module olst_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/olst_ctrl.sv =====
module olst_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  olst_req_if.sink            req_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output olst_pkg::result_t   res_o,
  output logic                mem_re_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  logic [31:0]         mem_rdata_i,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output logic [31:0]         mem_wdata_o
);

  localparam int unsigned PW = (CW > 7) ? CW : 7;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [2:0]        op_q, op_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [31:0]       val_q, val_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [AW-1:0]     ra_q, ra_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pa_q, pa_d;
  logic [CW-1:0]     w_q, w_d;
  logic              hit_q, hit_d;
  logic [1:0]        status_q, status_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [31:0]       rd_q, rd_d;
  olst_pkg::result_t res_q, res_d;

  logic [PW-1:0] pos_x;
  logic [PW-1:0] cnt_x;
  logic          full;
  logic          issue;

  assign pos_x = PW'(req_i.position);
  assign cnt_x = PW'(cnt_q);
  assign full  = (cnt_q == CW'(DEPTH));
  assign issue = (rem_q != '0);

  assign req_i.ready = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_HOLD);
  assign res_o       = res_q;

  // Sequencer: accept, walk the memory one read per cycle, commit, hold the result.
  always_comb begin
    logic [1:0]    st;
    logic [CW-1:0] cnt_n;
    state_d  = state_q;
    op_d     = op_q;
    pos_d    = pos_q;
    val_d    = val_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    ra_d     = ra_q;
    pend_d   = 1'b0;
    pa_d     = pa_q;
    w_d      = w_q;
    hit_d    = hit_q;
    status_d = status_q;
    idx_d    = idx_q;
    rd_d     = rd_q;
    res_d    = res_q;
    st       = olst_pkg::ST_OK;
    cnt_n    = cnt_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = ra_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pa_q;
    mem_wdata_o = mem_rdata_i;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d    = req_i.opcode;
          pos_d   = AW'(req_i.position);
          val_d   = req_i.value;
          w_d     = '0;
          hit_d   = 1'b0;
          idx_d   = '0;
          rd_d    = '0;
          rem_d   = '0;
          ra_d    = '0;
          state_d = S_SCAN;
          priority case (req_i.opcode)
            olst_pkg::OP_APPEND: begin
              st = full ? olst_pkg::ST_FULL : olst_pkg::ST_OK;
            end
            olst_pkg::OP_INSERT: begin
              if (pos_x > cnt_x) begin
                st = olst_pkg::ST_BADPOS;
              end else if (full) begin
                st = olst_pkg::ST_FULL;
              end else begin
                rem_d = CW'(cnt_x - pos_x);
                ra_d  = AW'(cnt_x - PW'(1));
              end
            end
            olst_pkg::OP_DEL_VAL, olst_pkg::OP_FIND: begin
              rem_d = cnt_q;
            end
            olst_pkg::OP_DEL_POS: begin
              if (pos_x >= cnt_x) begin
                st = olst_pkg::ST_BADPOS;
              end else begin
                rem_d = CW'(cnt_x - pos_x - PW'(1));
                ra_d  = AW'(pos_x + PW'(1));
              end
            end
            olst_pkg::OP_READ: begin
              if (pos_x >= cnt_x) begin
                st = olst_pkg::ST_BADPOS;
              end else begin
                rem_d = CW'(1);
                ra_d  = AW'(pos_x);
              end
            end
            default: begin
              st = olst_pkg::ST_OK;
            end
          endcase
          status_d = st;
        end
      end

      S_SCAN: begin
        // Issue the next read of the walk; inserts walk downward.
        if (issue) begin
          mem_re_o = 1'b1;
          pend_d   = 1'b1;
          pa_d     = ra_q;
          rem_d    = rem_q - CW'(1);
          ra_d     = (op_q == olst_pkg::OP_INSERT) ? ra_q - AW'(1) : ra_q + AW'(1);
        end

        // Handle the data of the read issued in the previous cycle.
        if (pend_q) begin
          unique case (op_q)
            olst_pkg::OP_INSERT: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = pa_q + AW'(1);
            end
            olst_pkg::OP_DEL_POS: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = pa_q - AW'(1);
            end
            olst_pkg::OP_DEL_VAL: begin
              if (mem_rdata_i != val_q) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = w_q[AW-1:0];
                w_d         = w_q + CW'(1);
              end
            end
            olst_pkg::OP_FIND: begin
              if (mem_rdata_i == val_q && !hit_q) begin
                hit_d  = 1'b1;
                idx_d  = pa_q;
                rem_d  = '0;
                pend_d = 1'b0;
                mem_re_o = 1'b0;
              end
            end
            olst_pkg::OP_READ: begin
              rd_d = mem_rdata_i;
            end
            default: begin
            end
          endcase
        end

        // Commit once the walk is drained.
        if (!issue && !pend_q) begin
          st = status_q;
          if (status_q == olst_pkg::ST_OK) begin
            unique case (op_q)
              olst_pkg::OP_APPEND: begin
                mem_we_o    = 1'b1;
                mem_waddr_o = cnt_q[AW-1:0];
                mem_wdata_o = val_q;
                cnt_n       = cnt_q + CW'(1);
              end
              olst_pkg::OP_INSERT: begin
                mem_we_o    = 1'b1;
                mem_waddr_o = pos_q;
                mem_wdata_o = val_q;
                cnt_n       = cnt_q + CW'(1);
              end
              olst_pkg::OP_DEL_POS: begin
                cnt_n = cnt_q - CW'(1);
              end
              olst_pkg::OP_DEL_VAL: begin
                if (w_q == cnt_q) begin
                  st = olst_pkg::ST_NOTFOUND;
                end
                cnt_n = w_q;
              end
              olst_pkg::OP_FIND: begin
                st = hit_q ? olst_pkg::ST_OK : olst_pkg::ST_NOTFOUND;
              end
              default: begin
              end
            endcase
          end
          cnt_d             = cnt_n;
          res_d.status      = st;
          res_d.found_index = 6'(idx_q);
          res_d.length      = 7'(cnt_n);
          res_d.read_value  = rd_q;
          state_d           = S_HOLD;
        end
      end

      S_HOLD: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rem_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      pend_q   <= pend_d;
    end
  end

  // Operands and scan bookkeeping.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    ra_q     <= ra_d;
    pa_q     <= pa_d;
    w_q      <= w_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    idx_q    <= idx_d;
    rd_q     <= rd_d;
    res_q    <= res_d;
  end

  // The count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("element count exceeds capacity");

  // No read data is left over when a new request can be taken.
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_q)
    else $error("read pending while idle");

  // The walk never reads and writes the same entry in one cycle.
  a_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o && mem_re_o |-> mem_waddr_o != mem_raddr_o)
    else $error("read and write hit the same entry");

  // An issued read always leaves its data pending in the next cycle.
  a_pend_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re_o |=> pend_q)
    else $error("issued read lost its data slot");

endmodule

// ===== sv/ordered_list_store.sv =====
// Channel   Dir  Fields                                        Transfer
// req_i     in   opcode, position, value                       valid && ready
// rsp_o     out  status, found_index, length, read_value       valid && ready
//
// An item walks the element memory with N reads after its transfer, then commits. N counts
// the reads of the single element memory port: 0 for append and for any
// refused request, length - position for insert, length - position - 1 for delete at a
// position, length for delete by value, first match index + 1 for find (length on a miss),
// and 1 for read. Reset clears the length and the control state, not the element memory.
// A result waits in the output register while the next request is taken and walked.
module ordered_list_store #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  olst_req_if.sink    req_i,
  olst_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [31:0]       mem_rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [31:0]       mem_wdata;
  logic              res_valid;
  logic              res_ready;
  olst_pkg::result_t res;
  logic              out_valid_q;
  olst_pkg::result_t out_q;

  olst_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  olst_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  // Output register: loads when empty or when its result transfers this cycle.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.found_index = out_q.found_index;
  assign rsp_o.length      = out_q.length;
  assign rsp_o.read_value  = out_q.read_value;

endmodule
